// ----- design/assert_macros.svh -----
// assertion helpers included by the design file sector_cache_priority_lru
// both macros expect clk and rst_n to be visible where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge out of reset
`define SCL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a rising clock edge out of reset
`define SCL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SCL_ASSERT(lbl, prop, msg)
`define SCL_NEVER(lbl, cond, msg)
`endif
`endif

// ----- design/sclru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclru_pkg
// types and codes shared by the sector cache replacement tracker
// ----------------------------------------------------------------------------
package sclru_pkg;

    localparam int SLOTS_DEF     = 32;
    localparam int LEVELS_DEF    = 3;
    localparam int LEVELS_MAX    = 4;
    localparam int LVL_W         = 2;
    localparam int PROMOTE_RESET = 50;

    // field widths of the channels
    localparam int FUNC_W   = 2;
    localparam int SECTOR_W = 32;
    localparam int PRI_W    = 2;
    localparam int RSLOT_W  = 5;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 3;
    localparam int THR_W    = 8;
    localparam int HITS_W   = 10;
    localparam int USERS_W  = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // request functions
    localparam logic [FUNC_W-1:0] FN_GET   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REL   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_INV   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_FLUSH = 2'd3;

    // release modes
    localparam logic [MODE_W-1:0] RM_WB    = 2'd1;
    localparam logic [MODE_W-1:0] RM_INVAL = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] K_HIT  = 3'd0;
    localparam logic [KIND_W-1:0] K_FILL = 3'd1;
    localparam logic [KIND_W-1:0] K_NULL = 3'd2;
    localparam logic [KIND_W-1:0] K_WB   = 3'd3;
    localparam logic [KIND_W-1:0] K_DONE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL    = 4'd1;

    localparam logic [HITS_W-1:0]  HITS_MAX  = '1;
    localparam logic [USERS_W-1:0] USERS_MAX = '1;

    typedef struct packed {
        logic [SECTOR_W-1:0] tag;
        logic                init;
        logic                dirty;
        logic                inval;
        logic [HITS_W-1:0]   hits;
        logic [LVL_W-1:0]    level;
        logic [USERS_W-1:0]  users;
    } slot_rec_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [RSLOT_W-1:0]  out_slot;
        logic [SECTOR_W-1:0] out_sector;
        logic [SECTOR_W-1:0] victim_sector;
        logic                victim_write;
        logic                last;
    } result_t;

endpackage

// ----- design/sclru_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclru channel interfaces
// request, result and configuration write channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface sclru_req_if import sclru_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SECTOR_W-1:0] sector;
    logic [PRI_W-1:0]    priority_req;
    logic [RSLOT_W-1:0]  slot;
    logic [MODE_W-1:0]   release_mode;
    logic                mark_dirty;

    modport source (output valid, func, sector, priority_req, slot, release_mode,
                    mark_dirty, input ready);
    modport sink (input valid, func, sector, priority_req, slot, release_mode,
                  mark_dirty, output ready);
endinterface

interface sclru_rsp_if import sclru_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [RSLOT_W-1:0]  out_slot;
    logic [SECTOR_W-1:0] out_sector;
    logic [SECTOR_W-1:0] victim_sector;
    logic                victim_write;
    logic                last;

    modport source (output valid, kind, out_slot, out_sector, victim_sector,
                    victim_write, last, input ready);
    modport sink (input valid, kind, out_slot, out_sector, victim_sector,
                  victim_write, last, output ready);
endinterface

interface sclru_cfg_if import sclru_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/sector_cache_priority_lru.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_priority_lru
// tag and multi-level lru replacement tracker for a sector cache
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  req      in   func, sector, priority_req, slot, release_mode, mark_dirty
//  rsp      out  kind, out_slot, out_sector, victim_sector, victim_write, last
//  cfg      in   index, data (register write, always ready)
//
//  one request at a time; get: tag scan through the slot memory, then unlink,
//  relink and output; release: read, update and output; invalidate-all and
//  flush-all walk every slot
//  reset is asynchronous; memories come up through per-entry valid bits
//  a stalled rsp holds the sequencer in the output state until the beat leaves
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sector_cache_priority_lru
    import sclru_pkg::*;
#(
    parameter int NUM_SLOTS  = SLOTS_DEF,
    parameter int NUM_LEVELS = LEVELS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    sclru_req_if.sink   req,
    sclru_rsp_if.source rsp,
    sclru_cfg_if.sink   cfg
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW = $clog2(NUM_SLOTS + 1);
    localparam logic [IW-1:0]    NIL    = IW'(NUM_SLOTS);
    localparam logic [LVL_W-1:0] LOWEST = LVL_W'(NUM_LEVELS - 1);
    localparam slot_rec_t REC_RST = '{tag: '0, init: 1'b0, dirty: 1'b0, inval: 1'b0,
                                      hits: '0, level: LOWEST, users: '0};

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_VRD, S_VGOT, S_LRD, S_UNL, S_HIT, S_FILL,
        S_PUSHB0, S_PUSHB1, S_REL0, S_REL1, S_INV_RD, S_INV_CK, S_INV_CLR,
        S_PUSHF0, S_PUSHF1, S_FL_RD, S_FL_CK, S_OUT
    } state_t;

    // result beat builder
    function automatic result_t make_res(logic [KIND_W-1:0] k, logic [RSLOT_W-1:0] sl,
                                         logic [SECTOR_W-1:0] sec,
                                         logic [SECTOR_W-1:0] vic, logic vw, logic lst);
        result_t r;
        r.kind          = k;
        r.out_slot      = sl;
        r.out_sector    = sec;
        r.victim_sector = vic;
        r.victim_write  = vw;
        r.last          = lst;
        return r;
    endfunction

    // configuration registers
    logic [THR_W-1:0]    thr_reg;
    logic [SECTOR_W-1:0] null_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_W'(PROMOTE_RESET);
            null_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PROMOTE: thr_reg  <= cfg.data[THR_W-1:0];
                CFG_NULL:    null_reg <= cfg.data[SECTOR_W-1:0];
                default:     ;
            endcase
        end
    end

    // slot record memory and the two link memories
    slot_rec_t       slot_mem [NUM_SLOTS];
    logic [IW-1:0]   next_mem [NUM_SLOTS];
    logic [IW-1:0]   prev_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_vld_reg, next_vld_reg, prev_vld_reg;

    logic [AW-1:0] slot_raddr, link_raddr;
    logic          slot_we, next_we, prev_we;
    logic [AW-1:0] slot_waddr, next_waddr, prev_waddr;
    slot_rec_t     slot_wdata;
    logic [IW-1:0] next_wdata, prev_wdata;

    slot_rec_t     slot_q_reg;
    logic [IW-1:0] next_q_reg, prev_q_reg;
    logic          slot_qv_reg, next_qv_reg, prev_qv_reg;
    logic [AW-1:0] link_qa_reg;

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        slot_q_reg  <= slot_mem[slot_raddr];
        next_q_reg  <= next_mem[link_raddr];
        prev_q_reg  <= prev_mem[link_raddr];
        link_qa_reg <= link_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
            next_vld_reg <= '0;
            prev_vld_reg <= '0;
            slot_qv_reg  <= 1'b0;
            next_qv_reg  <= 1'b0;
            prev_qv_reg  <= 1'b0;
        end
        else
        begin
            if (slot_we)
                slot_vld_reg[slot_waddr] <= 1'b1;
            if (next_we)
                next_vld_reg[next_waddr] <= 1'b1;
            if (prev_we)
                prev_vld_reg[prev_waddr] <= 1'b1;
            slot_qv_reg <= slot_vld_reg[slot_raddr];
            next_qv_reg <= next_vld_reg[link_raddr];
            prev_qv_reg <= prev_vld_reg[link_raddr];
        end
    end

    // never-written entries read as the reset chain 0..N-1
    slot_rec_t     slot_rd;
    logic [IW-1:0] next_rd, prev_rd;

    always_comb
    begin
        slot_rd = slot_qv_reg ? slot_q_reg : REC_RST;
        if (next_qv_reg)
            next_rd = next_q_reg;
        else if (IW'(link_qa_reg) == IW'(NUM_SLOTS - 1))
            next_rd = NIL;
        else
            next_rd = IW'(link_qa_reg) + IW'(1);
        if (prev_qv_reg)
            prev_rd = prev_q_reg;
        else if (link_qa_reg == '0)
            prev_rd = NIL;
        else
            prev_rd = IW'(link_qa_reg) - IW'(1);
    end

    // sequencer registers
    state_t state_reg, ret_reg;
    logic [IW-1:0]       idx_reg;
    logic                chk_reg;
    logic [AW-1:0]       s_reg;
    logic [IW-1:0]       t_reg;
    slot_rec_t           rec_reg;
    result_t             res_reg, out_reg;
    logic                ov_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [PRI_W-1:0]    pri_reg;
    logic [RSLOT_W-1:0]  rs_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic                md_reg;
    logic [IW-1:0]       head_reg [LEVELS_MAX];
    logic [IW-1:0]       tail_reg [LEVELS_MAX];

    // helpers
    logic              tag_match;
    logic [AW-1:0]     victim;
    logic [USERS_W-1:0] users_up;
    logic [HITS_W-1:0] hits_up;
    logic [HITS_W-1:0] promote_lim;
    logic              promote;
    logic [LVL_W-1:0]  fill_lvl;
    logic              flushable;
    slot_rec_t         rel_rec;
    slot_rec_t         hit_rec;

    always_comb
    begin
        tag_match = slot_rd.init && (slot_rd.tag == sector_reg);
        // lowest-priority non-empty level wins
        victim = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (head_reg[l] != NIL)
                victim = head_reg[l][AW-1:0];
        end
        users_up    = (rec_reg.users == USERS_MAX) ? USERS_MAX : rec_reg.users + 1'b1;
        hits_up     = (rec_reg.hits == HITS_MAX) ? HITS_MAX : rec_reg.hits + 1'b1;
        promote_lim = HITS_W'(rec_reg.level) * HITS_W'(thr_reg);
        promote     = (rec_reg.level != '0) && (hits_up > promote_lim);
        fill_lvl    = (int'(pri_reg) >= NUM_LEVELS) ? LOWEST : LVL_W'(pri_reg);
        flushable   = slot_rd.init && slot_rd.dirty && !slot_rd.inval;
        rel_rec     = slot_rd;
        if (md_reg)
            rel_rec.dirty = 1'b1;
        if (rel_rec.users != '0)
            rel_rec.users = rel_rec.users - 1'b1;
        if (mode_reg == RM_INVAL)
            rel_rec.inval = 1'b1;
        // hit update: count, maybe promote one level
        hit_rec       = rec_reg;
        hit_rec.users = users_up;
        if (promote)
        begin
            hit_rec.hits  = '0;
            hit_rec.level = rec_reg.level - 1'b1;
        end
        else
            hit_rec.hits = hits_up;
    end

    // memory port control
    always_comb
    begin
        slot_raddr = s_reg;
        link_raddr = s_reg;
        slot_we    = 1'b0;
        slot_waddr = s_reg;
        slot_wdata = rec_reg;
        next_we    = 1'b0;
        next_waddr = s_reg;
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_waddr = s_reg;
        prev_wdata = NIL;
        case (state_reg)
            S_SCAN, S_INV_RD, S_FL_RD:
                slot_raddr = idx_reg[AW-1:0];
            S_REL0:
                slot_raddr = AW'(rs_reg);
            S_UNL:
            begin
                next_we    = (prev_rd != NIL);
                next_waddr = prev_rd[AW-1:0];
                next_wdata = next_rd;
                prev_we    = (next_rd != NIL);
                prev_waddr = next_rd[AW-1:0];
                prev_wdata = prev_rd;
            end
            S_PUSHB0:
            begin
                slot_we    = 1'b1;
                next_we    = 1'b1;
                prev_we    = 1'b1;
                prev_wdata = tail_reg[rec_reg.level];
            end
            S_PUSHB1:
            begin
                next_we    = (t_reg != NIL);
                next_waddr = t_reg[AW-1:0];
                next_wdata = IW'(s_reg);
            end
            S_PUSHF0:
            begin
                slot_we    = 1'b1;
                next_we    = 1'b1;
                next_wdata = head_reg[LOWEST];
                prev_we    = 1'b1;
            end
            S_PUSHF1:
            begin
                prev_we    = (t_reg != NIL);
                prev_waddr = t_reg[AW-1:0];
                prev_wdata = IW'(s_reg);
            end
            S_REL1:
            begin
                slot_we    = 1'b1;
                slot_waddr = AW'(rs_reg);
                slot_wdata = rel_rec;
            end
            S_FL_CK:
            begin
                slot_we          = flushable;
                slot_wdata       = slot_rd;
                slot_wdata.dirty = 1'b0;
            end
            default: ;
        endcase
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = ov_reg;
    assign rsp.kind          = out_reg.kind;
    assign rsp.out_slot      = out_reg.out_slot;
    assign rsp.out_sector    = out_reg.out_sector;
    assign rsp.victim_sector = out_reg.victim_sector;
    assign rsp.victim_write  = out_reg.victim_write;
    assign rsp.last          = out_reg.last;

    localparam result_t RES_DONE = '{kind: K_DONE, out_slot: '0, out_sector: '0,
                                     victim_sector: '0, victim_write: 1'b0, last: 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            chk_reg   <= 1'b0;
            for (int l = 0; l < LEVELS_MAX; l++)
            begin
                head_reg[l] <= (l == int'(LOWEST)) ? '0 : NIL;
                tail_reg[l] <= (l == int'(LOWEST)) ? IW'(NUM_SLOTS - 1) : NIL;
            end
        end
        else
        begin
            // output register: loaded from S_OUT, emptied when the beat leaves
            ov_reg <= ((state_reg == S_OUT) && (!ov_reg || rsp.ready)) ||
                      (ov_reg && !rsp.ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        sector_reg <= req.sector;
                        pri_reg    <= req.priority_req;
                        rs_reg     <= req.slot;
                        mode_reg   <= req.release_mode;
                        md_reg     <= req.mark_dirty;
                        idx_reg    <= '0;
                        chk_reg    <= 1'b0;
                        ret_reg    <= S_IDLE;
                        case (req.func)
                            FN_GET:
                            begin
                                if (req.sector == null_reg)
                                begin
                                    res_reg   <= make_res(K_NULL, '0, '0, '0, 1'b0, 1'b1);
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_SCAN;
                            end
                            FN_REL:
                            begin
                                if (int'(req.slot) >= NUM_SLOTS)
                                begin
                                    res_reg   <= RES_DONE;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_REL0;
                            end
                            FN_INV:  state_reg <= S_INV_RD;
                            default: state_reg <= S_FL_RD;
                        endcase
                    end
                end
                // pipelined tag scan: compare the entry read last cycle
                S_SCAN:
                begin
                    if (chk_reg && tag_match)
                    begin
                        rec_reg   <= slot_rd;
                        ret_reg   <= slot_rd.inval ? S_FILL : S_HIT;
                        state_reg <= S_LRD;
                    end
                    else if (idx_reg == NIL)
                    begin
                        s_reg     <= victim;
                        ret_reg   <= S_FILL;
                        state_reg <= S_VRD;
                    end
                    else
                    begin
                        chk_reg <= 1'b1;
                        s_reg   <= idx_reg[AW-1:0];
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_VRD:
                    state_reg <= S_VGOT;
                S_VGOT:
                begin
                    rec_reg   <= slot_rd;
                    state_reg <= S_UNL;
                end
                S_LRD:
                    state_reg <= S_UNL;
                // unlink: neighbours written by the port logic, ends here
                S_UNL:
                begin
                    if (prev_rd == NIL)
                        head_reg[rec_reg.level] <= next_rd;
                    if (next_rd == NIL)
                        tail_reg[rec_reg.level] <= prev_rd;
                    state_reg <= ret_reg;
                end
                S_HIT:
                begin
                    rec_reg   <= hit_rec;
                    res_reg   <= make_res(K_HIT, RSLOT_W'(s_reg), sector_reg, '0, 1'b0, 1'b1);
                    state_reg <= S_PUSHB0;
                end
                S_FILL:
                begin
                    res_reg <= make_res(K_FILL, RSLOT_W'(s_reg), sector_reg, rec_reg.tag,
                                        rec_reg.init && !rec_reg.inval && rec_reg.dirty,
                                        1'b1);
                    rec_reg <= '{tag: sector_reg, init: 1'b1, dirty: 1'b0, inval: 1'b0,
                                 hits: HITS_W'(1), level: fill_lvl, users: USERS_W'(1)};
                    state_reg <= S_PUSHB0;
                end
                S_PUSHB0:
                begin
                    t_reg <= tail_reg[rec_reg.level];
                    if (tail_reg[rec_reg.level] == NIL)
                        head_reg[rec_reg.level] <= IW'(s_reg);
                    tail_reg[rec_reg.level] <= IW'(s_reg);
                    state_reg <= S_PUSHB1;
                end
                S_PUSHB1:
                begin
                    ret_reg   <= S_IDLE;
                    state_reg <= S_OUT;
                end
                S_REL0:
                    state_reg <= S_REL1;
                S_REL1:
                begin
                    res_reg   <= (mode_reg == RM_WB) ?
                                 make_res(K_WB, rs_reg, slot_rd.tag, '0, 1'b0, 1'b1) :
                                 RES_DONE;
                    ret_reg   <= S_IDLE;
                    state_reg <= S_OUT;
                end
                S_INV_RD:
                begin
                    if (idx_reg == NIL)
                    begin
                        res_reg   <= RES_DONE;
                        ret_reg   <= S_IDLE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        s_reg     <= idx_reg[AW-1:0];
                        state_reg <= S_INV_CK;
                    end
                end
                S_INV_CK:
                begin
                    rec_reg <= slot_rd;
                    if (slot_rd.users == '0 && slot_rd.init)
                    begin
                        ret_reg   <= S_INV_CLR;
                        state_reg <= S_UNL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_INV_RD;
                    end
                end
                S_INV_CLR:
                begin
                    rec_reg   <= REC_RST;
                    state_reg <= S_PUSHF0;
                end
                S_PUSHF0:
                begin
                    t_reg <= head_reg[LOWEST];
                    if (head_reg[LOWEST] == NIL)
                        tail_reg[LOWEST] <= IW'(s_reg);
                    head_reg[LOWEST] <= IW'(s_reg);
                    state_reg <= S_PUSHF1;
                end
                S_PUSHF1:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_INV_RD;
                end
                S_FL_RD:
                begin
                    if (idx_reg == NIL)
                    begin
                        res_reg   <= RES_DONE;
                        ret_reg   <= S_IDLE;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        s_reg     <= idx_reg[AW-1:0];
                        state_reg <= S_FL_CK;
                    end
                end
                S_FL_CK:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (flushable)
                    begin
                        res_reg   <= make_res(K_WB, RSLOT_W'(s_reg), slot_rd.tag, '0,
                                              1'b0, 1'b0);
                        ret_reg   <= S_FL_RD;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_FL_RD;
                end
                // hand the beat to the output register once it is free
                S_OUT:
                begin
                    if (!ov_reg || rsp.ready)
                    begin
                        out_reg   <= res_reg;
                        state_reg <= ret_reg;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    `SCL_ASSERT(a_ends_pair, (head_reg[0] == NIL) == (tail_reg[0] == NIL), "level ends disagree")
    `SCL_ASSERT(a_one_req, req.valid && req.ready |=> !req.ready, "second request taken")
    `SCL_NEVER(a_idx_range, idx_reg > NIL, "slot walk ran past the end")

endmodule

// ----- tb/sector_cache_priority_lru_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_priority_lru_test
// self-checking bench for the sector cache replacement tracker: an in-bench
// model of tags, flags and the per-level lru lists predicts every result
// beat, directed cases first, then random get/release/bulk traffic under
// several promote thresholds and null sectors, with random stalls both sides
// ----------------------------------------------------------------------------
module sector_cache_priority_lru_test;
    import sclru_pkg::*;

    localparam int NSLOT   = SLOTS_DEF;
    localparam int NLVL    = LEVELS_DEF;
    localparam int LOW_LVL = NLVL - 1;
    localparam int NIL     = NSLOT;
    localparam int WDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;

    sclru_req_if req ();
    sclru_rsp_if rsp ();
    sclru_cfg_if cfg ();

    sector_cache_priority_lru DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // model of the tracker state
    logic [SECTOR_W-1:0] tag_m [NSLOT];
    bit                  init_m [NSLOT];
    bit                  dirty_m [NSLOT];
    bit                  inval_m [NSLOT];
    int                  hits_m [NSLOT];
    int                  level_m [NSLOT];
    int                  users_m [NSLOT];
    int                  next_m [NSLOT];
    int                  prev_m [NSLOT];
    int                  head_m [NLVL];
    int                  tail_m [NLVL];
    int                  threshold_m;
    logic [SECTOR_W-1:0] null_sec_m;

    result_t expected_beats [$];
    int      err_cnt;
    int      quiet_cycles;
    bit      calm;      // no idling on either side while set

    // sectors reused often so that gets hit
    logic [SECTOR_W-1:0] sector_pool [40];

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // lru list helpers
    // ------------------------------------------------------------------------
    function automatic void unlink_slot(int s);
        int l;
        int p;
        int n;
        l = level_m[s];
        p = prev_m[s];
        n = next_m[s];
        if (p >= NSLOT)
            head_m[l] = n;
        else
            next_m[p] = n;
        if (n >= NSLOT)
            tail_m[l] = p;
        else
            prev_m[n] = p;
        next_m[s] = NIL;
        prev_m[s] = NIL;
    endfunction

    function automatic void append_slot(int s, int l);
        int t;
        t = tail_m[l];
        level_m[s] = l;
        next_m[s] = NIL;
        prev_m[s] = t;
        if (t >= NSLOT)
            head_m[l] = s;
        else
            next_m[t] = s;
        tail_m[l] = s;
    endfunction

    function automatic void prepend_slot(int s, int l);
        int h;
        h = head_m[l];
        level_m[s] = l;
        prev_m[s] = NIL;
        next_m[s] = h;
        if (h >= NSLOT)
            tail_m[l] = s;
        else
            prev_m[h] = s;
        head_m[l] = s;
    endfunction

    function automatic void queue_beat(logic [KIND_W-1:0] k, int s,
                                       logic [SECTOR_W-1:0] sec,
                                       logic [SECTOR_W-1:0] vic, bit vw, bit lst);
        result_t r;
        r.kind          = k;
        r.out_slot      = s[RSLOT_W-1:0];
        r.out_sector    = sec;
        r.victim_sector = vic;
        r.victim_write  = vw;
        r.last          = lst;
        expected_beats.push_back(r);
    endfunction

    function automatic void reset_model();
        threshold_m = PROMOTE_RESET;
        null_sec_m  = '0;
        for (int l = 0; l < NLVL; l++)
        begin
            head_m[l] = NIL;
            tail_m[l] = NIL;
        end
        for (int i = 0; i < NSLOT; i++)
        begin
            tag_m[i]   = '0;
            init_m[i]  = 0;
            dirty_m[i] = 0;
            inval_m[i] = 0;
            hits_m[i]  = 0;
            users_m[i] = 0;
            append_slot(i, LOW_LVL);
        end
    endfunction

    // ------------------------------------------------------------------------
    // expected beats of one accepted request
    // ------------------------------------------------------------------------
    function automatic void predict_request(logic [FUNC_W-1:0] f, logic [SECTOR_W-1:0] sec,
                                            logic [PRI_W-1:0] pri, logic [RSLOT_W-1:0] rs,
                                            logic [MODE_W-1:0] mode, bit md);
        int s;
        int l;
        int p;
        logic [SECTOR_W-1:0] old;
        bit vw;
        s = NIL;
        if (f == FN_GET)
        begin
            if (sec == null_sec_m)
            begin
                queue_beat(K_NULL, 0, '0, '0, 0, 1);
                return;
            end
            for (int i = 0; i < NSLOT; i++)
                if (init_m[i] && tag_m[i] == sec)
                begin
                    s = i;
                    break;
                end
            if (s < NSLOT && !inval_m[s])
            begin
                // hit: count, maybe promote one level, move to tail
                l = level_m[s];
                if (users_m[s] < 15)
                    users_m[s]++;
                unlink_slot(s);
                if (hits_m[s] < 1023)
                    hits_m[s]++;
                if (l != 0 && hits_m[s] > l * threshold_m)
                begin
                    l--;
                    hits_m[s] = 0;
                end
                append_slot(s, l);
                queue_beat(K_HIT, s, sec, '0, 0, 1);
            end
            else
            begin
                // miss takes the oldest slot of the lowest non-empty level; an invalid hit reuses its slot
                if (s >= NSLOT)
                begin
                    for (int lv = LOW_LVL; lv >= 0; lv--)
                        if (head_m[lv] < NSLOT)
                        begin
                            s = head_m[lv];
                            break;
                        end
                    if (s >= NSLOT)
                        s = 0;
                end
                unlink_slot(s);
                old = tag_m[s];
                vw  = init_m[s] && !inval_m[s] && dirty_m[s];
                p   = (pri >= NLVL) ? LOW_LVL : int'(pri);
                tag_m[s]   = sec;
                hits_m[s]  = 1;
                users_m[s] = 1;
                init_m[s]  = 1;
                dirty_m[s] = 0;
                inval_m[s] = 0;
                append_slot(s, p);
                queue_beat(K_FILL, s, sec, old, vw, 1);
            end
        end
        else if (f == FN_REL)
        begin
            if (md)
                dirty_m[rs] = 1;
            if (users_m[rs] > 0)
                users_m[rs]--;
            if (mode == RM_INVAL)
                inval_m[rs] = 1;
            if (mode == RM_WB)
                queue_beat(K_WB, rs, tag_m[rs], '0, 0, 1);
            else
                queue_beat(K_DONE, 0, '0, '0, 0, 1);
        end
        else if (f == FN_INV)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (users_m[i] != 0 || !init_m[i])
                    continue;
                unlink_slot(i);
                init_m[i]  = 0;
                dirty_m[i] = 0;
                inval_m[i] = 0;
                tag_m[i]   = '0;
                hits_m[i]  = 0;
                prepend_slot(i, LOW_LVL);
            end
            queue_beat(K_DONE, 0, '0, '0, 0, 1);
        end
        else
        begin
            for (int i = 0; i < NSLOT; i++)
                if (dirty_m[i] && !inval_m[i] && init_m[i])
                begin
                    queue_beat(K_WB, i, tag_m[i], '0, 0, 0);
                    dirty_m[i] = 0;
                end
            queue_beat(K_DONE, 0, '0, '0, 0, 1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // request sender, called at a rising edge; valid stays up, but for random idle gaps, between beats
    // ------------------------------------------------------------------------
    task automatic send_request(logic [FUNC_W-1:0] f, logic [SECTOR_W-1:0] sec,
                                logic [PRI_W-1:0] pri, logic [RSLOT_W-1:0] rs,
                                logic [MODE_W-1:0] mode, bit md);
        bit rdy;
        if (!calm && $urandom_range(99) < 18)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.func         <= f;
        req.sector       <= sec;
        req.priority_req <= pri;
        req.slot         <= rs;
        req.release_mode <= mode;
        req.mark_dirty   <= md;
        // ready sampled mid-cycle, so the edge after decides the beat
        do
        begin
            @(negedge clk);
            rdy = req.ready;
            @(posedge clk);
        end
        while (!rdy);
        predict_request(f, sec, pri, rs, mode, md);
    endtask

    // wait for every pending beat, then let the sequencer settle
    task automatic drain();
        req.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        bit rdy;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
        begin
            @(negedge clk);
            rdy = cfg.ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg.valid <= 1'b0;
        if (idx == CFG_PROMOTE)
            threshold_m = int'(val[THR_W-1:0]);
        else if (idx == CFG_NULL)
            null_sec_m = val;
    endtask

    task automatic get_sector(logic [SECTOR_W-1:0] sec, logic [PRI_W-1:0] pri);
        send_request(FN_GET, sec, pri, '0, '0, 1'b0);
    endtask

    task automatic release_slot(int s, logic [MODE_W-1:0] mode, bit md);
        send_request(FN_REL, $urandom(), PRI_W'($urandom()), s[RSLOT_W-1:0], mode, md);
    endtask

    // ------------------------------------------------------------------------
    // test cases
    // ------------------------------------------------------------------------

    // null sector at reset, fills across levels, hits without promotion at the reset threshold
    task automatic test_get_paths();
        get_sector('0, 2'd0);                 // reset null sector
        get_sector(32'hFFFF_FFFF, 2'd0);      // fill the oldest slot, level 0
        get_sector(32'h0000_0001, 2'd1);
        get_sector(32'h8000_0000, 2'd3);      // out-of-range level saturates
        get_sector(32'h5A5A_A5A5, 2'd2);
        get_sector(32'hFFFF_FFFF, 2'd3);      // hit at level 0
        get_sector(32'h0000_0001, 2'd0);      // hit at level 1
        get_sector(32'h8000_0000, 2'd0);
        drain();
    endtask

    // every release mode, dirty marking, in-use victims and the bulk passes
    task automatic test_release_and_bulk();
        release_slot(0, 2'd0, 1'b1);          // normal, marked dirty
        release_slot(1, RM_WB, 1'b1);         // write back now
        release_slot(2, RM_INVAL, 1'b0);      // invalidate
        release_slot(3, 2'd3, 1'b1);          // mode 3 behaves as normal
        release_slot(31, 2'd0, 1'b0);         // idle slot, user count stays at zero
        get_sector(32'h8000_0000, 2'd1);      // invalid hit reuses its slot
        send_request(FN_FLUSH, '0, '0, '0, '0, 1'b0);
        release_slot(0, 2'd0, 1'b1);
        send_request(FN_INV, '0, '0, '0, '0, 1'b0);
        send_request(FN_FLUSH, '0, '0, '0, '0, 1'b0);
        // victims evicted while still in use
        for (int i = 0; i < NSLOT + 2; i++)
            get_sector(32'h1000_0000 + i, 2'd2);
        drain();
    endtask

    // threshold of one: quick promotion from the lowest level to level 0
    task automatic test_promotion();
        write_register(CFG_PROMOTE, 32'd1);
        write_register(CFG_NULL, 32'hFFFF_FFFF);
        get_sector(32'hFFFF_FFFF, 2'd0);      // now null
        get_sector('0, 2'd2);                 // sector zero is cacheable now
        repeat (5) get_sector('0, 2'd2);
        drain();
    endtask

    // random traffic, mostly gets on a small working set
    task automatic test_random(int n_items);
        int r;
        logic [SECTOR_W-1:0] sec;
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                if ($urandom_range(9) == 0)
                    sec = $urandom();
                else if ($urandom_range(19) == 0)
                    sec = null_sec_m;
                else
                    sec = sector_pool[$urandom_range(39)];
                get_sector(sec, PRI_W'($urandom()));
            end
            else if (r < 88)
                release_slot($urandom_range(NSLOT - 1), MODE_W'($urandom()),
                             $urandom_range(1) != 0);
            else if (r < 94)
                send_request(FN_INV, $urandom(), PRI_W'($urandom()), RSLOT_W'($urandom()),
                             MODE_W'($urandom()), $urandom_range(1) != 0);
            else
                send_request(FN_FLUSH, $urandom(), PRI_W'($urandom()), RSLOT_W'($urandom()),
                             MODE_W'($urandom()), $urandom_range(1) != 0);
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, beats checked mid-cycle
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= calm || ($urandom_range(99) >= 18);
    end

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d slot %0d",
                       rsp.kind, rsp.out_slot);
                err_cnt++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (rsp.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
                    err_cnt++;
                end
                if (rsp.out_slot !== want.out_slot)
                begin
                    $error("out_slot: expected %0d, got %0d", want.out_slot, rsp.out_slot);
                    err_cnt++;
                end
                if (rsp.out_sector !== want.out_sector)
                begin
                    $error("out_sector: expected %h, got %h", want.out_sector,
                           rsp.out_sector);
                    err_cnt++;
                end
                if (rsp.victim_sector !== want.victim_sector)
                begin
                    $error("victim_sector: expected %h, got %h", want.victim_sector,
                           rsp.victim_sector);
                    err_cnt++;
                end
                if (rsp.victim_write !== want.victim_write)
                begin
                    $error("victim_write: expected %0d, got %0d", want.victim_write,
                           rsp.victim_write);
                    err_cnt++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp.last);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(negedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        err_cnt      = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        req.valid        = 1'b0;
        req.func         = FN_GET;
        req.sector       = '0;
        req.priority_req = '0;
        req.slot         = '0;
        req.release_mode = '0;
        req.mark_dirty   = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_PROMOTE;
        cfg.data  = '0;
        for (int i = 0; i < 40; i++)
            sector_pool[i] = (i < 2) ? {SECTOR_W{i[0]}} : $urandom();
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_get_paths();
        test_release_and_bulk();
        test_promotion();

        test_random(40);
        // highest threshold, a null sector from the working set
        write_register(CFG_PROMOTE, 32'd255);
        write_register(CFG_NULL, sector_pool[$urandom_range(2, 39)]);
        calm = 1'b1;
        test_random(40);
        calm = 1'b0;
        // zero threshold: every hit above level 0 promotes
        write_register(CFG_PROMOTE, 32'd0);
        write_register(CFG_NULL, $urandom());
        test_random(45);
        write_register(CFG_PROMOTE, 32'd2);
        write_register(CFG_NULL, 32'd0);
        test_random(40);

        drain();
        repeat (50) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
